FILE: src/ppi_pkg.sv
// Shared constants, phase types and header lookup for the periodic packet injector.
package ppi_pkg;

  localparam int FLIT_W        = 16;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int HEADER_FLITS  = 26;
  localparam int PAYLOAD_FLITS = 4;
  localparam int GAP_CYCLES    = 30;
  localparam int IDX_W         = 6;
  localparam int GAP_W         = 5;
  localparam int CNT_W         = 8;
  localparam int REWIND        = 3;

  localparam logic [FLIT_W-1:0] IO_SERVICE    = FLIT_W'(16'h0300);
  localparam logic [FLIT_W-1:0] SIZE_LIMIT    = FLIT_W'(16'h000B);
  localparam logic [FLIT_W-1:0] HDR_LEN_CODE  = FLIT_W'(11 + 2);
  localparam logic [FLIT_W-1:0] HDR_ROUTE_TAG = FLIT_W'(2);

  // receive-side flit positions
  localparam logic [CNT_W-1:0] POS_SIZE    = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_SERVICE = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_ID      = CNT_W'(11);
  localparam logic [CNT_W-1:0] CNT_CAPTURE = CNT_W'(14);
  localparam logic [CNT_W-1:0] CNT_SPLIT   = CNT_W'(HEADER_FLITS);

  // send-side header positions
  localparam logic [IDX_W-1:0] HP_FIXED_HI = IDX_W'(0);
  localparam logic [IDX_W-1:0] HP_FIXED_LO = IDX_W'(1);
  localparam logic [IDX_W-1:0] HP_ROUTE_HI = IDX_W'(2);
  localparam logic [IDX_W-1:0] HP_ROUTE_LO = IDX_W'(3);
  localparam logic [IDX_W-1:0] HP_LEN      = IDX_W'(5);
  localparam logic [IDX_W-1:0] HP_TYPE_HI  = IDX_W'(6);
  localparam logic [IDX_W-1:0] HP_TYPE_LO  = IDX_W'(7);
  localparam logic [IDX_W-1:0] HP_SERVICE  = IDX_W'(9);
  localparam logic [IDX_W-1:0] HP_PERIPH   = IDX_W'(11);
  localparam logic [IDX_W-1:0] HP_SRC_PE   = IDX_W'(13);
  localparam logic [IDX_W-1:0] HP_ROUTE_TG = IDX_W'(19);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_FIXED,
    CFG_HDR_ROUTE,
    CFG_TYPE_FLITS,
    CFG_SERVICE,
    CFG_SOURCE_PE,
    CFG_PERIOD,
    CFG_WIN_START,
    CFG_WIN_END
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RX_INIT,
    RX_RECEIVE,
    RX_WAIT,
    RX_SERVICE,
    RX_PAYLOAD
  } rx_phase_t;

  typedef enum logic [2:0] {
    TX_WAIT_REQ,
    TX_HEADER,
    TX_PAYLOAD,
    TX_WAIT_HEADER,
    TX_WAIT_PAYLOAD,
    TX_EOP
  } tx_phase_t;

  function automatic logic [FLIT_W-1:0] header_flit(
    input logic [IDX_W-1:0]  pos,
    input logic [CFG_W-1:0]  fixed_w,
    input logic [CFG_W-1:0]  route_w,
    input logic [CFG_W-1:0]  type_w,
    input logic [FLIT_W-1:0] service,
    input logic [FLIT_W-1:0] src_pe,
    input logic [FLIT_W-1:0] periph
  );
    logic [FLIT_W-1:0] v;
    unique case (pos)
      HP_FIXED_HI: v = fixed_w[CFG_W-1:FLIT_W];
      HP_FIXED_LO: v = fixed_w[FLIT_W-1:0];
      HP_ROUTE_HI: v = route_w[CFG_W-1:FLIT_W];
      HP_ROUTE_LO: v = route_w[FLIT_W-1:0];
      HP_LEN:      v = HDR_LEN_CODE;
      HP_TYPE_HI:  v = type_w[CFG_W-1:FLIT_W];
      HP_TYPE_LO:  v = type_w[FLIT_W-1:0];
      HP_SERVICE:  v = service;
      HP_PERIPH:   v = periph;
      HP_SRC_PE:   v = src_pe;
      HP_ROUTE_TG: v = HDR_ROUTE_TAG;
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/ppi_in_if.sv
// Input channel: one link cycle per beat.
interface ppi_in_if;
  import ppi_pkg::*;

  logic              valid;
  logic              ready;
  logic              rx_valid;
  logic [FLIT_W-1:0] rx_flit;
  logic              rx_end;
  logic              credit_in;

  modport source (output valid, output rx_valid, output rx_flit, output rx_end,
                  output credit_in, input ready);
  modport sink   (input valid, input rx_valid, input rx_flit, input rx_end,
                  input credit_in, output ready);
endinterface

FILE: src/ppi_out_if.sv
// Result channel: registered link outputs, one beat per input beat.
interface ppi_out_if;
  import ppi_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [FLIT_W-1:0] tx_flit;
  logic              tx_end;
  logic              service_req;

  modport source (output valid, output tx_valid, output tx_flit, output tx_end,
                  output service_req, input ready);
  modport sink   (input valid, input tx_valid, input tx_flit, input tx_end,
                  input service_req, output ready);
endinterface

FILE: src/ppi_cfg_if.sv
// Configuration write channel: register index and write data.
interface ppi_cfg_if;
  import ppi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/periodic_packet_injector.sv
// Periodic packet injector top level: receive counter, send sequencer, output register.
//
// Usage: every beat on in_ch is one cycle of the network link (incoming flit
// with its valid and end marks, plus downstream credit). For each beat the
// block returns one beat on out_ch with the link outputs after that cycle:
// tx_valid, tx_flit, tx_end and the sticky service_req flag.
// cfg_ch writes the eight configuration registers (header words, service and
// source codes, injection period, window bounds); it is always ready and
// should be written only while no beat is in flight.
// An accepted input beat's result beat is registered and offered in the next cycle.
// Throughput: one beat per cycle while out_ch is ready; both state machines and
// the window/period compare are combinational between the input and the result register.
// Stall: in_ch.ready follows out_ch.ready while a result is held, so a stalled
// receiver holds the result and no state advances until it is taken.
// Reset (rst_n low, synchronous): phases to their idle codes, counters,
// request flag, captured fields and configuration to zero, result register
// empty.
module periodic_packet_injector (
  input  logic clk,
  input  logic rst_n,
  ppi_in_if.sink    in_ch,
  ppi_out_if.source out_ch,
  ppi_cfg_if.sink   cfg_ch
);
  import ppi_pkg::*;

  // configuration
  logic [CFG_W-1:0]  hdr_fixed_r, hdr_route_r, type_flits_r;
  logic [FLIT_W-1:0] service_r, source_pe_r;
  logic [CFG_W-1:0]  period_r, win_start_r, win_end_r;

  // receive side
  rx_phase_t         rx_phase_r, rx_phase_nxt;
  logic [CNT_W-1:0]  rx_cnt_r, rx_cnt_nxt;
  logic [FLIT_W-1:0] store_size_r, store_svc_r, store_id_r;
  logic [FLIT_W-1:0] cap_size_r, cap_size_nxt;
  logic [FLIT_W-1:0] cap_svc_r, cap_svc_nxt;
  logic [FLIT_W-1:0] periph_id_r, periph_id_nxt;
  logic              req_r, req_nxt;

  // send side
  tx_phase_t         tx_phase_r, tx_phase_nxt;
  logic [IDX_W-1:0]  send_idx_r, send_idx_nxt;
  logic [CFG_W-1:0]  cycle_r, cycle_nxt;
  logic [CFG_W-1:0]  countdown_r, countdown_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [FLIT_W-1:0] latched_id_r, latched_id_nxt;
  logic              tx_valid_r, tx_valid_nxt;
  logic [FLIT_W-1:0] tx_flit_r, tx_flit_nxt;
  logic              tx_end_r, tx_end_nxt;

  logic              out_valid_r;
  logic              in_ready;
  logic              accept;

  logic              credit, rx, eop;
  logic [CNT_W-1:0]  rx_cnt_inc;
  logic              rx_take;
  logic [CFG_W-1:0]  cd_dec;
  logic              fire;
  logic [IDX_W-1:0]  rewind_idx, idx_inc, rewind_inc, flit_pos;
  logic [FLIT_W-1:0] hdr_val, pay_val;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  assign credit = in_ch.credit_in;
  assign rx     = in_ch.rx_valid;
  assign eop    = in_ch.rx_end;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_valid    = tx_valid_r;
  assign out_ch.tx_flit     = tx_flit_r;
  assign out_ch.tx_end      = tx_end_r;
  assign out_ch.service_req = req_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_fixed_r  <= '0;
      hdr_route_r  <= '0;
      type_flits_r <= '0;
      service_r    <= '0;
      source_pe_r  <= '0;
      period_r     <= '0;
      win_start_r  <= '0;
      win_end_r    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_HDR_FIXED:  hdr_fixed_r  <= cfg_ch.data;
        CFG_HDR_ROUTE:  hdr_route_r  <= cfg_ch.data;
        CFG_TYPE_FLITS: type_flits_r <= cfg_ch.data;
        CFG_SERVICE:    service_r    <= cfg_ch.data[FLIT_W-1:0];
        CFG_SOURCE_PE:  source_pe_r  <= cfg_ch.data[FLIT_W-1:0];
        CFG_PERIOD:     period_r     <= cfg_ch.data;
        CFG_WIN_START:  win_start_r  <= cfg_ch.data;
        CFG_WIN_END:    win_end_r    <= cfg_ch.data;
      endcase
    end
  end

  // ---------------------------------------------------------------- receive
  assign rx_cnt_inc = rx_cnt_r + CNT_W'(1);
  assign rx_take    = rx && (rx_phase_r == RX_INIT || rx_phase_r == RX_RECEIVE ||
                             rx_phase_r == RX_WAIT);

  always_comb begin
    rx_phase_nxt = rx_phase_r;
    unique case (rx_phase_r)
      RX_INIT:    if (rx) rx_phase_nxt = RX_RECEIVE;
      RX_RECEIVE: begin
        if (rx) begin
          if (rx_cnt_inc == CNT_SPLIT && cap_size_r > SIZE_LIMIT) rx_phase_nxt = RX_PAYLOAD;
          if (eop) rx_phase_nxt = RX_SERVICE;
        end else begin
          rx_phase_nxt = RX_WAIT;
        end
      end
      RX_WAIT:    if (rx) rx_phase_nxt = RX_RECEIVE;
      RX_SERVICE: rx_phase_nxt = RX_INIT;
      RX_PAYLOAD: if (eop) rx_phase_nxt = RX_SERVICE;
      default:    rx_phase_nxt = RX_INIT;
    endcase
  end

  always_comb begin
    rx_cnt_nxt    = rx_cnt_r;
    cap_size_nxt  = cap_size_r;
    cap_svc_nxt   = cap_svc_r;
    periph_id_nxt = periph_id_r;
    req_nxt       = req_r;
    if (rx_take) begin
      rx_cnt_nxt = rx_cnt_inc;
      if (rx_cnt_inc == CNT_CAPTURE) begin
        cap_size_nxt  = store_size_r;
        cap_svc_nxt   = store_svc_r;
        periph_id_nxt = store_id_r;
      end
    end
    unique case (rx_phase_r)
      RX_RECEIVE: begin
        if (rx) begin
          if (rx_cnt_inc == CNT_SPLIT && cap_size_r > SIZE_LIMIT) rx_cnt_nxt = '0;
          if (eop) rx_cnt_nxt = '0;
        end
      end
      RX_SERVICE: begin
        rx_cnt_nxt = '0;
        if (cap_svc_r == IO_SERVICE) req_nxt = 1'b1;
      end
      RX_PAYLOAD: rx_cnt_nxt = eop ? '0 : rx_cnt_inc;
      default: ;
    endcase
  end

  // header flits seen on the way in: no reset, read only after capture
  always_ff @(posedge clk) begin
    if (accept && rx_take) begin
      if (rx_cnt_r == POS_SIZE)    store_size_r <= in_ch.rx_flit;
      if (rx_cnt_r == POS_SERVICE) store_svc_r  <= in_ch.rx_flit;
      if (rx_cnt_r == POS_ID)      store_id_r   <= in_ch.rx_flit;
    end
  end

  // ---------------------------------------------------------------- send
  assign cycle_nxt  = cycle_r + CFG_W'(1);
  assign cd_dec     = (countdown_r != '0) ? countdown_r - CFG_W'(1) : '0;
  assign fire       = cycle_nxt > win_start_r && cycle_nxt < win_end_r && cd_dec == '0;
  assign rewind_idx = (send_idx_r > IDX_W'(REWIND)) ? send_idx_r - IDX_W'(REWIND) : '0;
  assign idx_inc    = send_idx_r + IDX_W'(1);
  assign rewind_inc = rewind_idx + IDX_W'(1);
  // resend after a credit loss starts from the rewound position
  assign flit_pos   = (tx_phase_r == TX_WAIT_HEADER || tx_phase_r == TX_WAIT_PAYLOAD) ?
                      rewind_idx : send_idx_r;
  assign hdr_val    = header_flit(flit_pos, hdr_fixed_r, hdr_route_r, type_flits_r,
                                  service_r, source_pe_r, latched_id_r);
  assign pay_val    = FLIT_W'(HEADER_FLITS) + FLIT_W'(flit_pos);

  always_comb begin
    tx_phase_nxt = tx_phase_r;
    unique case (tx_phase_r)
      TX_WAIT_REQ:     if (fire && credit) tx_phase_nxt = TX_HEADER;
      TX_HEADER: begin
        if (!credit) tx_phase_nxt = TX_WAIT_HEADER;
        else if (idx_inc == IDX_W'(HEADER_FLITS)) tx_phase_nxt = TX_PAYLOAD;
      end
      TX_PAYLOAD: begin
        if (!credit) tx_phase_nxt = TX_WAIT_PAYLOAD;
        else if (idx_inc == IDX_W'(PAYLOAD_FLITS)) tx_phase_nxt = TX_EOP;
      end
      TX_WAIT_HEADER:  if (credit) tx_phase_nxt = TX_HEADER;
      TX_WAIT_PAYLOAD: begin
        if (credit) begin
          tx_phase_nxt = (rewind_idx == IDX_W'(PAYLOAD_FLITS - 1)) ? TX_EOP : TX_PAYLOAD;
        end
      end
      TX_EOP:          if (gap_r == GAP_W'(GAP_CYCLES)) tx_phase_nxt = TX_WAIT_REQ;
      default:         tx_phase_nxt = TX_WAIT_REQ;
    endcase
  end

  always_comb begin
    send_idx_nxt   = send_idx_r;
    countdown_nxt  = cd_dec;
    gap_nxt        = gap_r;
    latched_id_nxt = latched_id_r;
    tx_valid_nxt   = tx_valid_r;
    tx_flit_nxt    = tx_flit_r;
    tx_end_nxt     = tx_end_r;
    unique case (tx_phase_r)
      TX_WAIT_REQ: begin
        if (fire) begin
          latched_id_nxt = periph_id_r;
          tx_flit_nxt    = hdr_fixed_r[CFG_W-1:FLIT_W];
          tx_valid_nxt   = 1'b1;
          if (credit) begin
            countdown_nxt = period_r;
            send_idx_nxt  = idx_inc;
          end
        end
      end
      TX_HEADER: begin
        if (credit) begin
          tx_flit_nxt  = hdr_val;
          send_idx_nxt = (idx_inc == IDX_W'(HEADER_FLITS)) ? '0 : idx_inc;
        end else begin
          tx_valid_nxt = 1'b0;
        end
      end
      TX_PAYLOAD: begin
        if (credit) begin
          tx_flit_nxt = pay_val;
          if (idx_inc == IDX_W'(PAYLOAD_FLITS)) begin
            tx_end_nxt   = 1'b1;
            send_idx_nxt = '0;
          end else begin
            send_idx_nxt = idx_inc;
          end
        end else begin
          tx_valid_nxt = 1'b0;
        end
      end
      TX_WAIT_HEADER: begin
        if (credit) begin
          tx_flit_nxt  = hdr_val;
          tx_valid_nxt = 1'b1;
          send_idx_nxt = rewind_inc;
        end
      end
      TX_WAIT_PAYLOAD: begin
        if (credit) begin
          tx_flit_nxt  = pay_val;
          tx_valid_nxt = 1'b1;
          if (rewind_idx == IDX_W'(PAYLOAD_FLITS - 1)) begin
            tx_end_nxt   = 1'b1;
            send_idx_nxt = rewind_idx;
          end else begin
            send_idx_nxt = rewind_inc;
          end
        end
      end
      TX_EOP: begin
        tx_valid_nxt = 1'b0;
        tx_end_nxt   = 1'b0;
        send_idx_nxt = '0;
        // restart the gap count one past zero when the idle ends
        gap_nxt      = (gap_r == GAP_W'(GAP_CYCLES)) ? GAP_W'(1) : gap_r + GAP_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r   <= RX_INIT;
      rx_cnt_r     <= '0;
      cap_size_r   <= '0;
      cap_svc_r    <= '0;
      periph_id_r  <= '0;
      req_r        <= 1'b0;
      tx_phase_r   <= TX_WAIT_REQ;
      send_idx_r   <= '0;
      cycle_r      <= '0;
      countdown_r  <= '0;
      gap_r        <= '0;
      latched_id_r <= '0;
      tx_valid_r   <= 1'b0;
      tx_flit_r    <= '0;
      tx_end_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        rx_phase_r   <= rx_phase_nxt;
        rx_cnt_r     <= rx_cnt_nxt;
        cap_size_r   <= cap_size_nxt;
        cap_svc_r    <= cap_svc_nxt;
        periph_id_r  <= periph_id_nxt;
        req_r        <= req_nxt;
        tx_phase_r   <= tx_phase_nxt;
        send_idx_r   <= send_idx_nxt;
        cycle_r      <= cycle_nxt;
        countdown_r  <= countdown_nxt;
        gap_r        <= gap_nxt;
        latched_id_r <= latched_id_nxt;
        tx_valid_r   <= tx_valid_nxt;
        tx_flit_r    <= tx_flit_nxt;
        tx_end_r     <= tx_end_nxt;
      end
      // hold the result beat until taken
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
